>>> rtl/core/csvtok_pkg.sv
`timescale 1ns / 1ps

package csvtok_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned FieldNumWidth = 10;
   localparam int unsigned CsrAddrWidth  = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [ByteWidth-1:0]     QuoteChar      = 8'h22;
   localparam logic [ByteWidth-1:0]     NulChar        = 8'h00;
   localparam logic [ByteWidth-1:0]     DelimReset     = 8'd44;
   localparam logic [FieldNumWidth-1:0] FieldNumMax    = 10'd1023;

   // register index = paddr / 4
   localparam logic [CsrAddrWidth-3:0]  RegDelimiter   = 1'b0;

   typedef enum logic [1:0] {
      MODE_OUT  = 2'd0,
      MODE_IN   = 2'd1,
      MODE_PEND = 2'd2
   } quote_mode_type;

   typedef struct packed {
      logic [ByteWidth-1:0]     out_byte;
      logic                     byte_valid;
      logic                     field_end;
      logic                     line_end;
      logic                     quote_error;
      logic [FieldNumWidth-1:0] field_number;
   } tok_result_type;

endpackage

>>> rtl/core/csvtok_req_if.sv
`timescale 1ns / 1ps

interface csvtok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_line;

   modport source (output valid, output data_byte, output end_of_line, input ready);
   modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

>>> rtl/core/csvtok_rsp_if.sv
`timescale 1ns / 1ps

interface csvtok_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic       line_end;
   logic       quote_error;
   logic [9:0] field_number;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output line_end, output quote_error, output field_number, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                   input line_end, input quote_error, input field_number, output ready);
endinterface

>>> rtl/core/csvtok_step.sv
`timescale 1ns / 1ps

// One byte of the tokenizer: next quote mode, next field count, and the result.
module csvtok_step #(
   parameter int unsigned CntWidth = 10,
   parameter int unsigned CntMax   = 1023
) (
   input  csvtok_pkg::quote_mode_type mode,
   input  logic [CntWidth-1:0]        cnt,
   input  logic [7:0]                 delimiter,
   input  logic [7:0]                 data_byte,
   input  logic                       end_of_line,
   output csvtok_pkg::quote_mode_type mode_next,
   output logic [CntWidth-1:0]        cnt_next,
   output logic                       has_result,
   output csvtok_pkg::tok_result_type result
);

   localparam int unsigned WideWidth =
      (CntWidth > csvtok_pkg::FieldNumWidth) ? CntWidth : csvtok_pkg::FieldNumWidth;

   logic [WideWidth-1:0] cnt_wide;
   logic                 is_quote;
   logic                 outside;
   logic [CntWidth-1:0]  cnt_inc;

   assign cnt_wide = WideWidth'(cnt);
   assign is_quote = (data_byte == csvtok_pkg::QuoteChar);
   assign cnt_inc  = (cnt < CntWidth'(CntMax)) ? cnt + CntWidth'(1) : cnt;

   always_comb begin
      mode_next  = mode;
      cnt_next   = cnt;
      has_result = 1'b0;
      outside    = 1'b0;
      result.out_byte     = csvtok_pkg::NulChar;
      result.byte_valid   = 1'b0;
      result.field_end    = 1'b0;
      result.line_end     = 1'b0;
      result.quote_error  = 1'b0;
      result.field_number = (cnt_wide > WideWidth'(csvtok_pkg::FieldNumMax)) ?
                            csvtok_pkg::FieldNumMax : cnt_wide[csvtok_pkg::FieldNumWidth-1:0];

      if (end_of_line) begin
         has_result         = 1'b1;
         result.field_end   = 1'b1;
         result.line_end    = 1'b1;
         result.quote_error = (mode == csvtok_pkg::MODE_IN);
         mode_next          = csvtok_pkg::MODE_OUT;
         cnt_next           = '0;
      end else begin
         case (mode)
            csvtok_pkg::MODE_IN: begin
               if (is_quote) begin
                  mode_next = csvtok_pkg::MODE_PEND;
               end else begin
                  has_result        = 1'b1;
                  result.out_byte   = data_byte;
                  result.byte_valid = 1'b1;
               end
            end
            csvtok_pkg::MODE_PEND: begin
               if (is_quote) begin
                  // doubled quote: one literal quote, still inside
                  mode_next         = csvtok_pkg::MODE_IN;
                  has_result        = 1'b1;
                  result.out_byte   = csvtok_pkg::QuoteChar;
                  result.byte_valid = 1'b1;
               end else begin
                  outside = 1'b1;
               end
            end
            default: begin
               outside = 1'b1;
            end
         endcase

         if (outside) begin
            if (is_quote) begin
               mode_next = csvtok_pkg::MODE_IN;
            end else if (data_byte == delimiter) begin
               mode_next        = csvtok_pkg::MODE_OUT;
               has_result       = 1'b1;
               result.field_end = 1'b1;
               cnt_next         = cnt_inc;
            end else begin
               mode_next         = csvtok_pkg::MODE_OUT;
               has_result        = 1'b1;
               result.out_byte   = data_byte;
               result.byte_valid = 1'b1;
            end
         end
      end
   end

endmodule

>>> rtl/core/csv_field_tokenizer.sv
`timescale 1ns / 1ps

// CSV field tokenizer: splits one line into fields, one byte per transfer.
// req channel: data_byte plus end_of_line; a transfer with end_of_line set
//   closes the line and its data_byte is ignored.
// rsp channel: at most one result per request - a field character, a field
//   end on the delimiter, or the line end (field_end + line_end, with
//   quote_error if a quoted section was left open). Opening quotes and the
//   first quote of a pair produce no result.
// csr port: APB-style, one register (delimiter, byte address 0, reset ',').
//   Write only while the block is idle.
// Throughput: one request per cycle while rsp is not stalled. The quote-mode and field
//   count update is one short step between the input register and the
//   result register, so it closes every cycle.
// Result path: a request passes the input register, then the result
//   register, before its result is valid on rsp.
// Stall: the result register holds while rsp.ready is low; the input
//   register fills behind it, after which req.ready drops.
// Reset: synchronous; clears both stages, quote mode (outside quotes), the
//   field count, and restores the delimiter to ','.
module csv_field_tokenizer #(
   parameter int unsigned MAX_FIELDS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   csvtok_req_if.sink                            req,
   csvtok_rsp_if.source                          rsp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [csvtok_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [csvtok_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [csvtok_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned CntWidth = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
   localparam int unsigned CntMax   = MAX_FIELDS - 1;

   // ---- configuration ----
   logic [7:0] delim_ff;
   logic       csr_wr;
   logic       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[csvtok_pkg::CsrAddrWidth-1:2] == csvtok_pkg::RegDelimiter);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? {{(csvtok_pkg::CsrDataWidth-8){1'b0}}, delim_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= csvtok_pkg::DelimReset;
      end else if (csr_wr) begin
         delim_ff <= csr_pwdata[7:0];
      end
   end

   // ---- input register ----
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eol_ff;
   logic       advance;   // input register moves through the step logic
   logic       req_xfer;

   assign advance   = in_valid_ff && (!rsp.valid || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req.data_byte;
         in_eol_ff  <= req.end_of_line;
      end
   end

   // ---- tokenizer state and step ----
   csvtok_pkg::quote_mode_type mode_ff, mode_in;
   logic [CntWidth-1:0]        cnt_ff, cnt_in;
   logic                       has_result;
   csvtok_pkg::tok_result_type result;

   csvtok_step #(
      .CntWidth (CntWidth),
      .CntMax   (CntMax)
   ) u_step (
      .mode        (mode_ff),
      .cnt         (cnt_ff),
      .delimiter   (delim_ff),
      .data_byte   (in_byte_ff),
      .end_of_line (in_eol_ff),
      .mode_next   (mode_in),
      .cnt_next    (cnt_in),
      .has_result  (has_result),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csvtok_pkg::MODE_OUT;
         cnt_ff  <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   // ---- result register ----
   logic                       out_valid_ff;
   csvtok_pkg::tok_result_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= has_result;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_byte     = out_ff.out_byte;
   assign rsp.byte_valid   = out_ff.byte_valid;
   assign rsp.field_end    = out_ff.field_end;
   assign rsp.line_end     = out_ff.line_end;
   assign rsp.quote_error  = out_ff.quote_error;
   assign rsp.field_number = out_ff.field_number;

   // ---- checks ----
   a_line_end_closes_field: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.line_end |-> out_ff.field_end && !out_ff.byte_valid)
      else $error("line end without field end");

   a_quote_error_at_line_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.quote_error |-> out_ff.line_end)
      else $error("quote error away from line end");

   a_eol_clears_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_eol_ff |=> mode_ff == csvtok_pkg::MODE_OUT && cnt_ff == '0)
      else $error("state not cleared after line end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CntWidth'(CntMax) >= cnt_ff)
      else $error("field count past its limit");

   a_no_result_while_pending: assert property (@(posedge clock) disable iff (reset)
      advance && !in_eol_ff && mode_ff == csvtok_pkg::MODE_IN
         && in_byte_ff == csvtok_pkg::QuoteChar |=> !out_valid_ff)
      else $error("result on first quote of a pair");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned MaxFields  = 1024;
   localparam int unsigned HoldCycles = 200;
   localparam logic [csvtok_pkg::CsrAddrWidth-1:0] DelimAddr =
      {csvtok_pkg::RegDelimiter, 2'b00};

   // one pending request transfer
   typedef struct packed {
      logic [csvtok_pkg::ByteWidth-1:0] data_byte;
      logic                             end_of_line;
   } line_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csvtok_req_if req_if ();
   csvtok_rsp_if rsp_if ();

   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [csvtok_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [csvtok_pkg::CsrDataWidth-1:0] csr_pwdata;
   logic [csvtok_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                                csr_pready;

   csv_field_tokenizer #(
      .MAX_FIELDS (MaxFields)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bytes waiting to be sent, and tokens the block still owes us
   line_byte_type              line_bytes[$];
   csvtok_pkg::tok_result_type pending_tokens[$];

   // tokenizer state as we expect it to be inside the block
   csvtok_pkg::quote_mode_type       quote_mode   = csvtok_pkg::MODE_OUT;
   int unsigned                      field_count  = 0;
   logic [csvtok_pkg::ByteWidth-1:0] active_delim = csvtok_pkg::DelimReset;

   // traffic shaping, changed between phases only (nonblocking, at an edge)
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   logic rsp_hold       = 1'b0;
   event hold_go;

   // bookkeeping for the run summary
   int fail_count     = 0;
   int bytes_in       = 0;
   int tokens_out     = 0;
   int lines_closed   = 0;
   int open_quotes    = 0;
   int max_field_seen = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Expected behavior of one accepted byte. Returns 1 when the byte
   // produces a token; the token is written to tok.
   //  - end of line always gives a token with field_end + line_end and
   //    flags quote_error only if still inside an open quoted section
   //    (a pending quote counts as closed)
   //  - inside quotes everything is data; a quote goes to pending
   //  - pending + quote is one literal quote, back inside quotes
   //  - pending + anything else is handled as outside quotes
   //  - outside, the quote wins over a delimiter of the same value
   //  - field index saturates at MaxFields-1, reported clamped to 1023
   // ------------------------------------------------------------------
   function automatic bit tokenize_byte(input logic [csvtok_pkg::ByteWidth-1:0] ch,
                                        input logic eol,
                                        output csvtok_pkg::tok_result_type tok);
      tok = '0;
      tok.field_number = (field_count > csvtok_pkg::FieldNumMax) ?
                         csvtok_pkg::FieldNumMax :
                         field_count[csvtok_pkg::FieldNumWidth-1:0];
      if (eol) begin
         tok.field_end   = 1'b1;
         tok.line_end    = 1'b1;
         tok.quote_error = (quote_mode == csvtok_pkg::MODE_IN);
         quote_mode  = csvtok_pkg::MODE_OUT;
         field_count = 0;
         return 1'b1;
      end
      if (quote_mode == csvtok_pkg::MODE_IN) begin
         if (ch == csvtok_pkg::QuoteChar) begin
            quote_mode = csvtok_pkg::MODE_PEND;
            return 1'b0;
         end
         tok.out_byte   = ch;
         tok.byte_valid = 1'b1;
         return 1'b1;
      end
      if (quote_mode == csvtok_pkg::MODE_PEND && ch == csvtok_pkg::QuoteChar) begin
         quote_mode     = csvtok_pkg::MODE_IN;
         tok.out_byte   = csvtok_pkg::QuoteChar;
         tok.byte_valid = 1'b1;
         return 1'b1;
      end
      // outside quotes, or a pending quote closed by this byte
      if (ch == csvtok_pkg::QuoteChar) begin
         quote_mode = csvtok_pkg::MODE_IN;
         return 1'b0;
      end
      quote_mode = csvtok_pkg::MODE_OUT;
      if (ch == active_delim) begin
         tok.field_end = 1'b1;
         if (field_count < MaxFields - 1)
            field_count++;
         return 1'b1;
      end
      tok.out_byte   = ch;
      tok.byte_valid = 1'b1;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers the next queued byte whenever the channel is
   // free, idling at random per send_idle_pct. valid gets at most one
   // nonblocking write per edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      line_byte_type next_char;
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.data_byte   <= '0;
         req_if.end_of_line <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_char = line_bytes.pop_front();
            req_if.valid       <= 1'b1;
            req_if.data_byte   <= next_char.data_byte;
            req_if.end_of_line <= next_char.end_of_line;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result sink: random stalls, plus a long hold-off when asked for.
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Long receiver hold-off so the block backs up and drops req ready.
   always begin
      @(hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result transfer against the oldest expected
   // token, then predicts from the request transfer of the same edge.
   // Doing both in one block keeps push/pop order fixed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      csvtok_pkg::tok_result_type seen;
      csvtok_pkg::tok_result_type want;
      csvtok_pkg::tok_result_type predicted;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.out_byte     = rsp_if.out_byte;
            seen.byte_valid   = rsp_if.byte_valid;
            seen.field_end    = rsp_if.field_end;
            seen.line_end     = rsp_if.line_end;
            seen.quote_error  = rsp_if.quote_error;
            seen.field_number = rsp_if.field_number;
            tokens_out++;
            if (seen.line_end)
               lines_closed++;
            if (seen.quote_error)
               open_quotes++;
            if (int'(seen.field_number) > max_field_seen)
               max_field_seen = int'(seen.field_number);
            if (pending_tokens.size() == 0) begin
               $error("unexpected result transfer: byte %02h bv %0b fe %0b le %0b qe %0b fn %0d",
                      seen.out_byte, seen.byte_valid, seen.field_end, seen.line_end,
                      seen.quote_error, seen.field_number);
               fail_count++;
            end else begin
               want = pending_tokens.pop_front();
               if (seen.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, seen.out_byte);
                  fail_count++;
               end
               if (seen.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b", want.byte_valid, seen.byte_valid);
                  fail_count++;
               end
               if (seen.field_end !== want.field_end) begin
                  $error("field_end: expected %0b, got %0b", want.field_end, seen.field_end);
                  fail_count++;
               end
               if (seen.line_end !== want.line_end) begin
                  $error("line_end: expected %0b, got %0b", want.line_end, seen.line_end);
                  fail_count++;
               end
               if (seen.quote_error !== want.quote_error) begin
                  $error("quote_error: expected %0b, got %0b", want.quote_error,
                         seen.quote_error);
                  fail_count++;
               end
               if (seen.field_number !== want.field_number) begin
                  $error("field_number: expected %0d, got %0d", want.field_number,
                         seen.field_number);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            bytes_in++;
            if (tokenize_byte(req_if.data_byte, req_if.end_of_line, predicted))
               pending_tokens.push_back(predicted);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_char(input logic [csvtok_pkg::ByteWidth-1:0] ch);
      line_bytes.push_back('{data_byte: ch, end_of_line: 1'b0});
   endtask

   // data_byte is don't-care on end of line; randomize it anyway
   task automatic push_eol();
      line_bytes.push_back('{data_byte: csvtok_pkg::ByteWidth'($urandom_range(255)),
                             end_of_line: 1'b1});
   endtask

   // any byte that is neither quote nor the current delimiter
   function automatic logic [csvtok_pkg::ByteWidth-1:0] plain_char();
      logic [csvtok_pkg::ByteWidth-1:0] ch;
      do ch = csvtok_pkg::ByteWidth'($urandom_range(255));
      while (ch == csvtok_pkg::QuoteChar || ch == active_delim);
      return ch;
   endfunction

   // well-formed field: plain text, optionally a quoted section in the
   // middle holding delimiters and doubled quotes
   task automatic queue_field();
      logic [csvtok_pkg::ByteWidth-1:0] ch;
      repeat ($urandom_range(3)) push_char(plain_char());
      if ($urandom_range(1)) begin
         push_char(csvtok_pkg::QuoteChar);
         repeat ($urandom_range(5)) begin
            case ($urandom_range(4))
               0: push_char(active_delim);
               1: begin
                  push_char(csvtok_pkg::QuoteChar);
                  push_char(csvtok_pkg::QuoteChar);
               end
               default: begin
                  ch = csvtok_pkg::ByteWidth'($urandom_range(255));
                  push_char(ch);
                  if (ch == csvtok_pkg::QuoteChar)
                     push_char(csvtok_pkg::QuoteChar);
               end
            endcase
         end
         push_char(csvtok_pkg::QuoteChar);
         repeat ($urandom_range(2)) push_char(plain_char());
      end
   endtask

   // mostly well-formed lines; one in five is quote/delimiter noise,
   // which is where unterminated quotes come from
   task automatic queue_random_line();
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(3))
               0: push_char(csvtok_pkg::QuoteChar);
               1: push_char(active_delim);
               default: push_char(csvtok_pkg::ByteWidth'($urandom_range(255)));
            endcase
         end
      end else begin
         queue_field();
         repeat ($urandom_range(3)) begin
            push_char(active_delim);
            queue_field();
         end
      end
      push_eol();
   endtask

   task automatic queue_random_lines(input int count);
      int target;
      target = line_bytes.size() + count;
      while (line_bytes.size() < target)
         queue_random_line();
   endtask

   // Wait for every queued byte to be taken and every token to come back,
   // then let the two-stage pipe flush bytes that produce no token.
   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      while (line_bytes.size() != 0 || req_if.valid)
         @(negedge clock);
      while (pending_tokens.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (pending_tokens.size() != 0) begin
         $error("%0d expected results never arrived", pending_tokens.size());
         fail_count += pending_tokens.size();
         pending_tokens.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   // APB write of the delimiter, then read it back. Block must be idle.
   task automatic set_delimiter(input logic [csvtok_pkg::ByteWidth-1:0] value);
      logic [csvtok_pkg::CsrDataWidth-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DelimAddr;
      csr_pwdata  <= csvtok_pkg::CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      active_delim = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[csvtok_pkg::ByteWidth-1:0] !== value) begin
         $error("delimiter readback: expected %02h, got %02h", value,
                readback[csvtok_pkg::ByteWidth-1:0]);
         fail_count++;
      end
   endtask

   task automatic run_phase(input logic [csvtok_pkg::ByteWidth-1:0] delim_value,
                            input int idle, input int stall, input int count);
      set_delimiter(delim_value);
      @(posedge clock);
      send_idle_pct <= idle;
      rsp_stall_pct <= stall;
      @(negedge clock);
      queue_random_lines(count);
      drain();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed line set on the reset delimiter (comma):
      // zero byte and 0xFF as data, a delimiter, a delimiter kept inside
      // quotes, a doubled quote, a quote closed by the delimiter, a pending
      // quote at end of line (no error), an open quote at end of line
      // (error), an empty line, and a pending quote closed by plain data.
      @(negedge clock);
      push_char(csvtok_pkg::NulChar);
      push_char(8'hFF);
      push_char(csvtok_pkg::DelimReset);
      push_char(csvtok_pkg::QuoteChar);
      push_char(csvtok_pkg::DelimReset);
      push_char(csvtok_pkg::QuoteChar);
      push_char(csvtok_pkg::QuoteChar);
      push_char("x");
      push_char(csvtok_pkg::QuoteChar);
      push_char(csvtok_pkg::DelimReset);
      push_char(csvtok_pkg::QuoteChar);
      push_char(csvtok_pkg::QuoteChar);
      push_eol();
      push_char(csvtok_pkg::QuoteChar);
      push_char("z");
      push_eol();
      push_eol();
      push_char(csvtok_pkg::QuoteChar);
      push_char("a");
      push_char(csvtok_pkg::QuoteChar);
      push_char("b");
      push_char(csvtok_pkg::DelimReset);
      push_eol();
      drain();

      // Random lines across delimiter extremes and idle/stall mixes:
      // 0x00, 0xFF, the quote itself (quote must win), and tab.
      run_phase(8'h00, 0, 0, 90);
      run_phase(8'hFF, 57, 0, 90);
      run_phase(csvtok_pkg::QuoteChar, 0, 57, 90);
      run_phase(8'h09, 29, 29, 90);

      // Back-pressure: receiver holds off while the sender keeps offering,
      // so both pipe stages fill and req ready drops.
      set_delimiter(csvtok_pkg::ByteWidth'($urandom_range(255)));
      @(posedge clock);
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      @(negedge clock);
      -> hold_go;
      queue_random_lines(40);
      drain();

      $display("Summary: %0d bytes in, %0d results out over %0d lines, %0d open quotes flagged",
               bytes_in, tokens_out, lines_closed, open_quotes);
      $display("Summary: delimiters comma, 0x00, 0xFF, quote, tab, random; max field index %0d",
               max_field_seen);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #5_000_000;
      $error("run timed out");
      $display("Regression FAIL");
      $finish;
   end

endmodule
